[hw/rtl/cbt_pkg.sv]
// Package for the cubic Bezier tessellator: widths, register indexes and the
// load/run control bundle shared by the bit-serial units.
// No dependencies.
`default_nettype none
package cbt_pkg;
  localparam int COORD_BITS   = 16;
  localparam int SEG_BITS     = 6;
  localparam int MAX_SEG_DEF  = 63;
  localparam int T_BITS       = 16;
  localparam int Q_BITS       = T_BITS + 1;
  localparam int SQ_BITS      = 2 * Q_BITS;
  localparam int CUBE_BITS    = SQ_BITS + Q_BITS;
  localparam int W_BITS       = 49;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 3 * COORD_BITS;
  localparam int SUM_BITS     = COORD_BITS + 4;
  localparam int ACC_BITS     = COORD_BITS + 5;

  localparam logic [CFG_AW-1:0] REG_START  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_HANDLE1 = 3'd1;
  localparam logic [CFG_AW-1:0] REG_HANDLE2 = 3'd2;
  localparam logic [CFG_AW-1:0] REG_END    = 3'd3;

  typedef struct packed {
    logic load;
    logic run;
  } unit_ctl_t;
endpackage
`default_nettype wire

[hw/rtl/cubic_bezier_tessellator.sv]
// Top level of the cubic Bezier tessellator: config registers, sequencer,
// divider, multipliers and per-axis bit-serial evaluators. Depends on cbt_pkg.
//
//  channel | dir | handshake          | payload
//  in_     | in  | tvalid/tready      | tdata[5:0] segment_count
//  out_    | out | tvalid/tready      | tdata x,y,z; tlast last_point
//  cfg_    | in  | we (no wait)       | addr register index, wdata value
//
// Each point passes through the divider, the two multiply passes and the
// 49-bit serial weighted sum, then is presented until the output takes it.
// A request with count n yields n+1 points; count zero yields none.
// Input is taken only while idle; synchronous reset clears control and config.
`default_nettype none
module cubic_bezier_tessellator #(
  parameter int MAX_SEGMENTS = cbt_pkg::MAX_SEG_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,   // [5:0] segment_count
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [47:0]                      out_tdata,  // point_x, point_y, point_z
  output logic                             out_tlast,  // last_point
  input  wire logic                        cfg_we,
  input  wire logic [cbt_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [cbt_pkg::CFG_DW-1:0]  cfg_wdata
);
  localparam int CB = cbt_pkg::COORD_BITS;
  localparam int SB = cbt_pkg::SEG_BITS;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MULA, S_MULB, S_EVAL, S_OUT} state_t;

  state_t                          state_r, state_nxt;
  logic [5:0]                      cnt_r, cnt_nxt;
  logic [SB-1:0]                   n_r, n_nxt, i_r, i_nxt, n_in, n_sat;
  logic [cbt_pkg::CFG_DW-1:0]      ctrl_r [4];
  logic [cbt_pkg::W_BITS-1:0]      w_r [4];
  logic [cbt_pkg::W_BITS-1:0]      w_nxt [4];
  logic [cbt_pkg::T_BITS-1:0]      quo;
  logic [cbt_pkg::Q_BITS-1:0]      t_q, s_q;
  logic [cbt_pkg::SQ_BITS-1:0]     s2, t2;
  logic [cbt_pkg::CUBE_BITS-1:0]   prod [4];
  logic [3:0]                      wbit;
  logic signed [CB-1:0]            coord [3];
  cbt_pkg::unit_ctl_t              div_ctl, mula_ctl, mulb_ctl, eval_ctl;
  logic                            last_pt;

  assign n_in  = in_tdata[SB-1:0];
  assign n_sat = (32'(n_in) > MAX_SEGMENTS) ? SB'(MAX_SEGMENTS) : n_in;
  assign last_pt = (i_r == n_r);
  assign t_q = last_pt ? {1'b1, {cbt_pkg::T_BITS{1'b0}}} : {1'b0, quo};
  assign s_q = {1'b1, {cbt_pkg::T_BITS{1'b0}}} - t_q;

  assign div_ctl  = '{load: state_r == S_DIV  && cnt_r == '0, run: state_r == S_DIV  && cnt_r != '0};
  assign mula_ctl = '{load: state_r == S_MULA && cnt_r == '0, run: state_r == S_MULA && cnt_r != '0};
  assign mulb_ctl = '{load: state_r == S_MULB && cnt_r == '0, run: state_r == S_MULB && cnt_r != '0};
  assign eval_ctl = '{load: state_r == S_EVAL && cnt_r == '0, run: state_r == S_EVAL && cnt_r != '0};

  cbt_tdiv u_div (.clk(clk), .ctl(div_ctl), .idx(i_r), .div(n_r), .quo(quo));

  cbt_mul #(.AW(cbt_pkg::Q_BITS), .BW(cbt_pkg::Q_BITS)) u_ss (
    .clk(clk), .ctl(mula_ctl), .a(s_q), .b(s_q), .prod(s2));
  cbt_mul #(.AW(cbt_pkg::Q_BITS), .BW(cbt_pkg::Q_BITS)) u_tt (
    .clk(clk), .ctl(mula_ctl), .a(t_q), .b(t_q), .prod(t2));
  cbt_mul #(.AW(cbt_pkg::SQ_BITS), .BW(cbt_pkg::Q_BITS)) u_w0 (
    .clk(clk), .ctl(mulb_ctl), .a(s2), .b(s_q), .prod(prod[0]));
  cbt_mul #(.AW(cbt_pkg::SQ_BITS), .BW(cbt_pkg::Q_BITS)) u_w1 (
    .clk(clk), .ctl(mulb_ctl), .a(s2), .b(t_q), .prod(prod[1]));
  cbt_mul #(.AW(cbt_pkg::SQ_BITS), .BW(cbt_pkg::Q_BITS)) u_w2 (
    .clk(clk), .ctl(mulb_ctl), .a(t2), .b(s_q), .prod(prod[2]));
  cbt_mul #(.AW(cbt_pkg::SQ_BITS), .BW(cbt_pkg::Q_BITS)) u_w3 (
    .clk(clk), .ctl(mulb_ctl), .a(t2), .b(t_q), .prod(prod[3]));

  // handle weights carry their factor of 3 in the coefficient
  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    logic signed [CB+1:0] c0, c1, c2, c3;
    assign c0 = (CB+2)'($signed(ctrl_r[0][ax*CB +: CB]));
    assign c1 = (CB+2)'($signed(ctrl_r[1][ax*CB +: CB]) * 3);
    assign c2 = (CB+2)'($signed(ctrl_r[2][ax*CB +: CB]) * 3);
    assign c3 = (CB+2)'($signed(ctrl_r[3][ax*CB +: CB]));
    cbt_eval u_eval (.clk(clk), .ctl(eval_ctl), .c0(c0), .c1(c1), .c2(c2), .c3(c3),
                     .wbit(wbit), .coord(coord[ax]));
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      wbit[k]  = w_r[k][0];
      w_nxt[k] = w_r[k];
      if (eval_ctl.load) w_nxt[k] = prod[k][cbt_pkg::W_BITS-1:0];
      else if (eval_ctl.run) w_nxt[k] = w_r[k] >> 1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 6'd1;
    n_nxt     = n_r;
    i_nxt     = i_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid && n_in != '0) begin
          n_nxt     = n_sat;
          i_nxt     = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: if (cnt_r == 6'(cbt_pkg::T_BITS)) begin
        state_nxt = S_MULA;
        cnt_nxt   = '0;
      end
      S_MULA: if (cnt_r == 6'(cbt_pkg::Q_BITS)) begin
        state_nxt = S_MULB;
        cnt_nxt   = '0;
      end
      S_MULB: if (cnt_r == 6'(cbt_pkg::Q_BITS)) begin
        state_nxt = S_EVAL;
        cnt_nxt   = '0;
      end
      S_EVAL: if (cnt_r == 6'(cbt_pkg::W_BITS)) begin
        state_nxt = S_OUT;
        cnt_nxt   = '0;
      end
      S_OUT: begin
        cnt_nxt = '0;
        if (out_tready) begin
          if (last_pt) state_nxt = S_IDLE;
          else begin
            i_nxt     = i_r + SB'(1);
            state_nxt = S_DIV;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      n_r     <= '0;
      i_r     <= '0;
      for (int k = 0; k < 4; k++) ctrl_r[k] <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      n_r     <= n_nxt;
      i_r     <= i_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          cbt_pkg::REG_START:   ctrl_r[0] <= cfg_wdata;
          cbt_pkg::REG_HANDLE1: ctrl_r[1] <= cfg_wdata;
          cbt_pkg::REG_HANDLE2: ctrl_r[2] <= cfg_wdata;
          cbt_pkg::REG_END:     ctrl_r[3] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) w_r[k] <= w_nxt[k];
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {coord[2], coord[1], coord[0]};
  assign out_tlast  = last_pt;
endmodule
`default_nettype wire

[hw/rtl/cbt_tdiv.sv]
// Restoring divider, one quotient bit per cycle: t = floor(i * 2^16 / n).
// Depends on cbt_pkg.
`default_nettype none
module cbt_tdiv (
  input  wire logic                          clk,
  input  wire cbt_pkg::unit_ctl_t            ctl,
  input  wire logic [cbt_pkg::SEG_BITS-1:0]  idx,
  input  wire logic [cbt_pkg::SEG_BITS-1:0]  div,
  output logic      [cbt_pkg::T_BITS-1:0]    quo
);
  logic [cbt_pkg::SEG_BITS:0]   rem_r, rem_nxt;
  logic [cbt_pkg::T_BITS-1:0]   quo_r, quo_nxt;
  logic [cbt_pkg::SEG_BITS:0]   dbl;
  logic                         ge;

  always_comb begin
    dbl     = {rem_r[cbt_pkg::SEG_BITS-1:0], 1'b0};
    ge      = dbl >= {1'b0, div};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (ctl.load) begin
      rem_nxt = {1'b0, idx};
      quo_nxt = '0;
    end else if (ctl.run) begin
      rem_nxt = ge ? dbl - {1'b0, div} : dbl;
      quo_nxt = {quo_r[cbt_pkg::T_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign quo = quo_r;
endmodule
`default_nettype wire

[hw/rtl/cbt_mul.sv]
// Shift-add multiplier, one multiplier bit per cycle.
// Depends on cbt_pkg.
`default_nettype none
module cbt_mul #(
  parameter int AW = 17,
  parameter int BW = 17
) (
  input  wire logic               clk,
  input  wire cbt_pkg::unit_ctl_t ctl,
  input  wire logic [AW-1:0]      a,
  input  wire logic [BW-1:0]      b,
  output logic      [AW+BW-1:0]   prod
);
  logic [AW-1:0] a_r, a_nxt;
  logic [AW:0]   acc_r, acc_nxt, sum;
  logic [BW-1:0] lo_r, lo_nxt;

  always_comb begin
    sum     = acc_r + (lo_r[0] ? {1'b0, a_r} : '0);
    a_nxt   = a_r;
    acc_nxt = acc_r;
    lo_nxt  = lo_r;
    if (ctl.load) begin
      a_nxt   = a;
      acc_nxt = '0;
      lo_nxt  = b;
    end else if (ctl.run) begin
      acc_nxt = {1'b0, sum[AW:1]};
      lo_nxt  = {sum[0], lo_r[BW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    acc_r <= acc_nxt;
    lo_r  <= lo_nxt;
  end

  assign prod = {acc_r[AW-1:0], lo_r};
endmodule
`default_nettype wire

[hw/rtl/cbt_eval.sv]
// One axis of the Bernstein sum, weights consumed one bit per cycle LSB first;
// rounds the 2^48-scaled total to nearest. Depends on cbt_pkg.
`default_nettype none
module cbt_eval (
  input  wire logic                                   clk,
  input  wire cbt_pkg::unit_ctl_t                     ctl,
  input  wire logic signed [cbt_pkg::COORD_BITS+1:0]  c0,
  input  wire logic signed [cbt_pkg::COORD_BITS+1:0]  c1,
  input  wire logic signed [cbt_pkg::COORD_BITS+1:0]  c2,
  input  wire logic signed [cbt_pkg::COORD_BITS+1:0]  c3,
  input  wire logic        [3:0]                      wbit,
  output logic signed      [cbt_pkg::COORD_BITS-1:0]  coord
);
  localparam int AB = cbt_pkg::ACC_BITS;
  logic signed [AB-1:0] hi_r, hi_nxt, addend, sum, rnd;
  logic [1:0]           drop_r, drop_nxt;

  always_comb begin
    addend = (wbit[0] ? AB'(c0) : '0) + (wbit[1] ? AB'(c1) : '0)
           + (wbit[2] ? AB'(c2) : '0) + (wbit[3] ? AB'(c3) : '0);
    sum      = hi_r + addend;
    hi_nxt   = hi_r;
    drop_nxt = drop_r;
    if (ctl.load) begin
      hi_nxt   = '0;
      drop_nxt = '0;
    end else if (ctl.run) begin
      hi_nxt   = sum >>> 1;
      drop_nxt = {sum[0], drop_r[1]};
    end
    rnd = (hi_r <<< 1) + AB'(drop_r[1]) + AB'(drop_r[0]);
  end

  always_ff @(posedge clk) begin
    hi_r   <= hi_nxt;
    drop_r <= drop_nxt;
  end

  assign coord = rnd[cbt_pkg::COORD_BITS-1:0];
endmodule
`default_nettype wire

[hw/rtl/cbt_chk.sv]
// Port-level checker for cubic_bezier_tessellator, bound to the top level.
// Depends on cubic_bezier_tessellator.
`default_nettype none
module cbt_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata,
  input wire logic        out_tlast
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input taken while a point is pending");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tdata[5:0] != 6'd0) |=> !in_tready)
    else $error("still ready after a nonzero request");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled point changed");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (!out_tvalid && in_tready))
    else $error("not idle after last point");
endmodule

bind cubic_bezier_tessellator cbt_chk u_cbt_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tlast(out_tlast)
);
`default_nettype wire

[sim/tb.sv]
// Testbench for cubic_bezier_tessellator: a directed table, then random segment counts
// under several idle/stall phases, each checked against a fixed-point curve predictor.
// Depends on cbt_pkg and the RTL top level only.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [cbt_pkg::CFG_AW-1:0] REG_UNUSED = 3'd5;
  localparam int unsigned ONE_Q16 = 65536;
  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int SETTLE_CYCLES = 24;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        last;
  } point_t;

  typedef struct {
    bit                         is_cfg;
    logic [cbt_pkg::CFG_AW-1:0] addr;
    logic [cbt_pkg::CFG_DW-1:0] data;
    logic [5:0]                 count;
    bit                         typed;
    logic [15:0]                coord;
  } row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [7:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [47:0] out_tdata;
  logic cfg_we;
  logic [cbt_pkg::CFG_AW-1:0] cfg_addr;
  logic [cbt_pkg::CFG_DW-1:0] cfg_wdata;

  logic [cbt_pkg::CFG_DW-1:0] ctrl_pts [4];
  point_t point_q [$];
  row_t dir_tab [$];
  int errors = 0;
  int points_seen = 0;
  int items_sent = 0;
  int cycles = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  cubic_bezier_tessellator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic logic [15:0] blend_axis(longint unsigned wt[4], int axis);
    logic signed [95:0] acc;
    logic signed [95:0] rnd;
    longint c;
    acc = 0;
    for (int k = 0; k < 4; k++) begin
      c = longint'($signed(ctrl_pts[k][16*axis +: 16]));
      acc = acc + 96'(c) * 96'(wt[k]);
    end
    rnd = acc + (96'sd1 <<< 47);
    rnd = rnd >>> 48;
    return rnd[15:0];
  endfunction

  function automatic void predict_curve(logic [5:0] n);
    longint unsigned t, s;
    longint unsigned wt[4];
    point_t p;
    for (int i = 0; i <= n; i++) begin
      t = (i == n) ? ONE_Q16 : (longint'(i) * ONE_Q16) / n;
      s = ONE_Q16 - t;
      wt[0] = s * s * s;
      wt[1] = 3 * s * s * t;
      wt[2] = 3 * s * t * t;
      wt[3] = t * t * t;
      p.x = blend_axis(wt, 0);
      p.y = blend_axis(wt, 1);
      p.z = blend_axis(wt, 2);
      p.last = (i == n);
      point_q = {point_q, p};
    end
  endfunction

  // receiver: stall decision at falling edge, check at rising edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    point_t e;
    if (rst_n && out_tvalid && out_tready) begin
      points_seen++;
      if (point_q.size() == 0) begin
        $error("unexpected point x=%h y=%h z=%h", out_tdata[15:0], out_tdata[31:16],
               out_tdata[47:32]);
        errors++;
      end else begin
        e = point_q.pop_front();
        if (out_tdata[15:0] !== e.x) begin
          $error("point_x expected %h got %h", e.x, out_tdata[15:0]); errors++;
        end
        if (out_tdata[31:16] !== e.y) begin
          $error("point_y expected %h got %h", e.y, out_tdata[31:16]); errors++;
        end
        if (out_tdata[47:32] !== e.z) begin
          $error("point_z expected %h got %h", e.z, out_tdata[47:32]); errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last_point expected %b got %b", e.last, out_tlast); errors++;
        end
      end
    end
  end

  task automatic send_count(logic [5:0] n, bit typed, logic [15:0] coord);
    point_t p;
    if ($urandom_range(99) < gap_pct) begin
      in_tvalid = 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tvalid = 1;
    in_tdata = {2'b00, n};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (typed) begin
      for (int i = 0; n != 0 && i <= n; i++) begin
        p.x = coord; p.y = coord; p.z = coord; p.last = (i == n);
        point_q = {point_q, p};
      end
    end else begin
      if (n != 0) predict_curve(n);
    end
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 0;
    while (point_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [cbt_pkg::CFG_AW-1:0] a, logic [cbt_pkg::CFG_DW-1:0] d);
    cfg_we = 1; cfg_addr = a; cfg_wdata = d;
    @(negedge clk);
    cfg_we = 0;
    if (a <= cbt_pkg::REG_END) ctrl_pts[a[1:0]] = d;
  endtask

  function automatic logic [cbt_pkg::CFG_DW-1:0] rand_point();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  function automatic logic [5:0] rand_count();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 6'd0;
    if (r < 80) return 6'($urandom_range(1, 8));
    if (r < 95) return 6'($urandom_range(9, 62));
    return 6'd63;
  endfunction

  function automatic void add_cfg(logic [cbt_pkg::CFG_AW-1:0] a,
                                  logic [cbt_pkg::CFG_DW-1:0] d);
    row_t row;
    row = '{1'b1, a, d, 6'd0, 1'b0, 16'd0};
    dir_tab = {dir_tab, row};
  endfunction

  function automatic void add_item(logic [5:0] n, bit typed, logic [15:0] c);
    row_t row;
    row = '{1'b0, cbt_pkg::REG_START, 48'd0, n, typed, c};
    dir_tab = {dir_tab, row};
  endfunction

  initial begin
    row_t r;
    rst_n = 0;
    in_tvalid = 0; in_tdata = 0;
    out_tready = 0;
    cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
    for (int k = 0; k < 4; k++) ctrl_pts[k] = 0;

    // zero points after reset, constant curves, an ignored register index, then predicted curves
    add_item(6'd1, 1, 16'h0000);
    add_item(6'd63, 1, 16'h0000);
    add_item(6'd0, 1, 16'h0000);
    add_cfg(cbt_pkg::REG_START, {3{16'h7fff}});
    add_cfg(cbt_pkg::REG_HANDLE1, {3{16'h7fff}});
    add_cfg(cbt_pkg::REG_HANDLE2, {3{16'h7fff}});
    add_cfg(cbt_pkg::REG_END, {3{16'h7fff}});
    add_item(6'd5, 1, 16'h7fff);
    add_cfg(cbt_pkg::REG_START, {3{16'h8000}});
    add_cfg(cbt_pkg::REG_HANDLE1, {3{16'h8000}});
    add_cfg(cbt_pkg::REG_HANDLE2, {3{16'h8000}});
    add_cfg(cbt_pkg::REG_END, {3{16'h8000}});
    add_item(6'd2, 1, 16'h8000);
    add_cfg(REG_UNUSED, {3{16'h1234}});
    add_item(6'd3, 1, 16'h8000);
    add_cfg(cbt_pkg::REG_HANDLE1, {3{16'h7fff}});
    add_cfg(cbt_pkg::REG_END, {16'h7fff, 16'h8000, 16'h7fff});
    add_item(6'd1, 0, 0);
    add_item(6'd2, 0, 0);
    add_item(6'd32, 0, 0);
    add_item(6'd62, 0, 0);
    add_item(6'd63, 0, 0);
    add_item(6'd0, 0, 0);
    add_item(6'd21, 0, 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      if (r.is_cfg) begin
        drain();
        write_reg(r.addr, r.data);
      end else begin
        send_count(r.count, r.typed, r.coord);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 67; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 67; end
        default: begin gap_pct = 23; stall_pct = 23; end
      endcase
      if (ph == 2) begin
        write_reg(cbt_pkg::REG_START, {3{16'h8000}});
        write_reg(cbt_pkg::REG_HANDLE1, {16'h7fff, 16'h8000, 16'h7fff});
        write_reg(cbt_pkg::REG_HANDLE2, {16'h8000, 16'h7fff, 16'h8000});
        write_reg(cbt_pkg::REG_END, {3{16'h7fff}});
      end else begin
        write_reg(cbt_pkg::REG_START, rand_point());
        write_reg(cbt_pkg::REG_HANDLE1, rand_point());
        write_reg(cbt_pkg::REG_HANDLE2, rand_point());
        write_reg(cbt_pkg::REG_END, rand_point());
        write_reg(3'($urandom_range(4, 7)), rand_point());
      end
      for (int j = 0; j < 52; j++) begin
        if (j % 13 == 12) begin
          gap_pct = (ph == 0) ? 67 : 0;
          stall_pct = (ph == 0) ? 67 : 0;
        end else if (j % 13 == 3) begin
          gap_pct = (ph == 1) ? 67 : (ph == 3) ? 23 : 0;
          stall_pct = (ph == 2) ? 67 : (ph == 3) ? 23 : 0;
        end
        send_count(rand_count(), 0, 0);
      end
    end

    drain();
    if (point_q.size() != 0) begin
      $error("%0d points never arrived", point_q.size());
      errors++;
    end
    $display("Summary: %0d segment requests and %0d curve points across four pacing phases",
             items_sent, points_seen);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
